### hdl/sfcc_pkg.sv
// shared constants, types and the crc-8 step function of the sensor frame decoder
package sfcc_pkg;

	// crc-8 of each two-byte word
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	// byte positions within a six-byte frame
	localparam logic [2:0] POS_T_MSB = 3'd0;
	localparam logic [2:0] POS_T_LSB = 3'd1;
	localparam logic [2:0] POS_T_CRC = 3'd2;
	localparam logic [2:0] POS_H_MSB = 3'd3;
	localparam logic [2:0] POS_H_LSB = 3'd4;
	localparam logic [2:0] POS_H_CRC = 3'd5;

	// conversion constants
	localparam logic [14:0] TEMP_SCALE = 15'd17500;
	localparam logic [13:0] HUM_SCALE  = 14'd10000;
	localparam logic [15:0] FULL_SCALE = 16'hFFFF;
	localparam logic [14:0] C_OFFSET   = 15'd4500;
	// floor(9*x/5) as (x * 9 * ceil(2^18/5)) >> 18, exact for 9*x below 2^18
	localparam logic [18:0] F_MUL      = 19'd471861;
	localparam logic [15:0] F_OFFSET   = 16'd4900;

	// controller commands to the datapath
	typedef struct packed {
		logic take;
		logic mul_en;
		logic div_en;
		logic fmul_en;
		logic load;
	} sfcc_cmd_t;

	// one byte through the crc-8, msb first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### hdl/sfcc_byte_if.sv
// channel carrying received sensor bytes
interface sfcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_frame;

	modport source (output valid, output data_byte, output start_frame, input ready);
	modport sink (input valid, input data_byte, input start_frame, output ready);
endinterface

### hdl/sfcc_result_if.sv
// channel carrying decoded frame results
interface sfcc_result_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] temp_centi_c;
	logic signed [15:0] temp_centi_f;
	logic        [13:0] humidity_centi;
	logic               frame_valid;

	modport source (output valid, output temp_centi_c, output temp_centi_f,
		output humidity_centi, output frame_valid, input ready);
	modport sink (input valid, input temp_centi_c, input temp_centi_f,
		input humidity_centi, input frame_valid, output ready);
endinterface

### hdl/sfcc_ctrl.sv
// controller: byte acceptance, conversion sequencing and output register control
module sfcc_ctrl
	import sfcc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  logic      frame_end,
	output sfcc_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_FMUL = 3'd3;
	localparam logic [2:0] ST_LOAD = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_next   = state_q;
		in_ready     = 1'b0;
		cmd          = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
				if (in_valid && frame_end) begin
					state_next = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_next = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_en = 1'b1;
				state_next = ST_FMUL;
			end
			ST_FMUL: begin
				cmd.fmul_en = 1'b1;
				state_next  = ST_LOAD;
			end
			ST_LOAD: begin
				if (out_free) begin
					cmd.load   = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/sfcc_dp.sv
// datapath: frame tracking, crc check, raw words and unit conversion
module sfcc_dp
	import sfcc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  sfcc_cmd_t          cmd,
	input  logic [7:0]         data_byte,
	input  logic               start_frame,
	output logic               frame_end,
	output logic signed [14:0] temp_centi_c,
	output logic signed [15:0] temp_centi_f,
	output logic        [13:0] humidity_centi,
	output logic               frame_valid
);

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [15:0] temp_q;
	logic [15:0] humid_q;
	logic        fail_q;

	logic [2:0]  pos_eff;
	logic [7:0]  crc_next;

	logic [30:0] tprod_q;
	logic [29:0] hprod_q;
	logic [14:0] cq_q;
	logic [13:0] hq_q;
	logic [33:0] fprod_q;

	logic [16:0] tsum;
	logic [15:0] hsum;
	logic [14:0] tq;
	logic [13:0] hq;

	logic [14:0] temp_c_q;
	logic [15:0] temp_f_q;
	logic [13:0] humid_out_q;
	logic        valid_out_q;

	// effective position, start flag resynchronises
	assign pos_eff   = (start_frame || pos_q > POS_H_CRC) ? POS_T_MSB : pos_q;
	assign frame_end = (pos_eff == POS_H_CRC);
	assign crc_next  = crc8_byte((pos_eff == POS_T_MSB) ? CRC_INIT : crc_q, data_byte);

	// frame state, updated on each byte transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_T_MSB;
			crc_q   <= CRC_INIT;
			temp_q  <= '0;
			humid_q <= '0;
			fail_q  <= 1'b0;
		end else if (cmd.take) begin
			pos_q <= frame_end ? POS_T_MSB : pos_eff + 3'd1;
			case (pos_eff)
				POS_T_MSB: begin
					fail_q <= 1'b0;
					crc_q  <= crc_next;
					temp_q <= {data_byte, 8'h00};
				end
				POS_T_LSB: begin
					crc_q       <= crc_next;
					temp_q[7:0] <= data_byte;
				end
				POS_H_MSB: begin
					crc_q   <= crc_next;
					humid_q <= {data_byte, 8'h00};
				end
				POS_H_LSB: begin
					crc_q        <= crc_next;
					humid_q[7:0] <= data_byte;
				end
				default: begin
					if (crc_q != data_byte) begin
						fail_q <= 1'b1;
					end
					crc_q <= CRC_INIT;
				end
			endcase
		end
	end

	// division by 65535: q = (x >> 16) plus one when (x >> 16) + (x mod 2^16) reaches 65535
	assign tsum = 17'(tprod_q[30:16]) + 17'(tprod_q[15:0]);
	assign hsum = 16'(hprod_q[29:16]) + hprod_q[15:0];
	assign tq   = tprod_q[30:16] + 15'(tsum >= 17'(FULL_SCALE));
	assign hq   = hprod_q[29:16] + 14'(hsum >= FULL_SCALE || hsum < 16'(hprod_q[15:0]));

	// conversion steps: scale, divide, fahrenheit scale
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			tprod_q <= 31'(temp_q) * 31'(TEMP_SCALE);
			hprod_q <= 30'(humid_q) * 30'(HUM_SCALE);
		end
		if (cmd.div_en) begin
			cq_q <= tq;
			hq_q <= hq;
		end
		if (cmd.fmul_en) begin
			fprod_q <= 34'(cq_q) * 34'(F_MUL);
		end
	end

	// result register, zeros on a crc failure
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (fail_q) begin
				temp_c_q    <= '0;
				temp_f_q    <= '0;
				humid_out_q <= '0;
				valid_out_q <= 1'b0;
			end else begin
				temp_c_q    <= cq_q - C_OFFSET;
				temp_f_q    <= fprod_q[33:18] - F_OFFSET;
				humid_out_q <= hq_q;
				valid_out_q <= 1'b1;
			end
		end
	end

	assign temp_centi_c   = $signed(temp_c_q);
	assign temp_centi_f   = $signed(temp_f_q);
	assign humidity_centi = humid_out_q;
	assign frame_valid    = valid_out_q;

endmodule

### hdl/sensor_frame_crc_convert.sv
// top level of the sensor frame decoder: crc-8 word check and unit conversion
// bytes are taken one per cycle, except while a conversion runs
// the sixth byte starts a conversion (scale multiply, divide by 65535,
// fahrenheit multiply, result load) during which no byte is taken
// the result turns valid with the result load, which waits while the output is stalled
// asynchronous active-low reset returns to frame position zero with crc preset to 0xff
module sensor_frame_crc_convert
	import sfcc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	sfcc_byte_if.sink     bytes,
	sfcc_result_if.source result
);

	sfcc_cmd_t cmd;
	logic      frame_end;

	// control
	sfcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (bytes.valid),
		.in_ready  (bytes.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.frame_end (frame_end),
		.cmd       (cmd)
	);

	// datapath
	sfcc_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.data_byte      (bytes.data_byte),
		.start_frame    (bytes.start_frame),
		.frame_end      (frame_end),
		.temp_centi_c   (result.temp_centi_c),
		.temp_centi_f   (result.temp_centi_f),
		.humidity_centi (result.humidity_centi),
		.frame_valid    (result.frame_valid)
	);

	// a result load never overwrites a result still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !(result.valid && !result.ready))
		else $error("result register overwritten");

	// the closing byte of a frame starts the conversion
	a_frame_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && frame_end) |=> cmd.mul_en)
		else $error("conversion not started after frame end");

	// a failed frame carries zero values
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.frame_valid) |->
		(result.temp_centi_c == 15'sd0 && result.temp_centi_f == 16'sd0 &&
		result.humidity_centi == 14'd0))
		else $error("failed frame has non-zero values");

	// humidity never exceeds full scale
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.frame_valid) |-> (result.humidity_centi <= 14'd10000))
		else $error("humidity out of range");

endmodule

### tb/tb_top.sv
// self-checking testbench of the sensor frame decoder: crc-checked frames in, readings out
`timescale 1ns / 100ps

module tb_top
	import sfcc_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int RANDOM_BYTES   = 1750;
	localparam int N_PHASES       = 4;
	// idling per phase: none, sender only, receiver only, both
	localparam int SEND_IDLE_PCT [N_PHASES] = '{0, 47, 0, 6};
	localparam int RECV_STALL_PCT[N_PHASES] = '{0, 0, 47, 6};

	typedef struct packed {
		logic [7:0] data;
		logic       sof;
	} sensor_byte_t;

	typedef struct packed {
		logic signed [14:0] temp_c;
		logic signed [15:0] temp_f;
		logic        [13:0] hum;
		logic               ok;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// tb-side drive of the byte channel, known from time zero
	logic       byte_valid = 1'b0;
	logic [7:0] byte_data = 8'h00;
	logic       byte_sof = 1'b0;
	logic       res_ready = 1'b0;

	sfcc_byte_if   bytes_if ();
	sfcc_result_if result_if ();

	assign bytes_if.valid       = byte_valid;
	assign bytes_if.data_byte   = byte_data;
	assign bytes_if.start_frame = byte_sof;
	assign result_if.ready      = res_ready;

	sensor_frame_crc_convert dut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (bytes_if),
		.result (result_if)
	);

	sensor_byte_t byte_backlog[$];
	reading_t     readings_due[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int error_count = 0;
	int bytes_sent = 0;
	int frames_good = 0;
	int frames_rejected = 0;
	int queued_bytes = 0;
	int quiet_cycles = 0;
	bit aligned = 1'b1;

	// decoder state as the predictor sees it
	logic [2:0]  frm_pos = POS_T_MSB;
	logic [7:0]  frm_crc = CRC_INIT;
	logic [15:0] raw_temp = 16'h0000;
	logic [15:0] raw_hum = 16'h0000;
	logic        crc_bad = 1'b0;

	// clock and the single reset pulse
	initial begin
		fork
			forever #1 clk = ~clk;
			begin
				repeat (4) @(posedge clk);
				arst_n <= 1'b1;
			end
		join_none
	end

	// crc-8, polynomial 0x31, msb first
	function automatic logic [7:0] crc8_update(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		return r;
	endfunction

	// advance the frame state by one transfer, queue a reading after the sixth byte
	task automatic decode_byte(input logic [7:0] b, input logic sof);
		logic [2:0] slot;
		reading_t   rd;
		int         c_val;
		int         f_val;
		int         h_val;
		slot = (sof || frm_pos > POS_H_CRC) ? POS_T_MSB : frm_pos;
		case (slot)
			POS_T_MSB: begin
				crc_bad  = 1'b0;
				frm_crc  = crc8_update(CRC_INIT, b);
				raw_temp = {b, 8'h00};
			end
			POS_T_LSB: begin
				frm_crc  = crc8_update(frm_crc, b);
				raw_temp = {raw_temp[15:8], b};
			end
			POS_H_MSB: begin
				frm_crc = crc8_update(frm_crc, b);
				raw_hum = {b, 8'h00};
			end
			POS_H_LSB: begin
				frm_crc = crc8_update(frm_crc, b);
				raw_hum = {raw_hum[15:8], b};
			end
			default: begin
				if (frm_crc != b) crc_bad = 1'b1;
				frm_crc = CRC_INIT;
			end
		endcase
		if (slot != POS_H_CRC) begin
			frm_pos = slot + 3'd1;
		end else begin
			frm_pos = POS_T_MSB;
			if (crc_bad) begin
				rd = '0;
			end else begin
				c_val = (17500 * int'(raw_temp)) / 65535 - 4500;
				// offset keeps the dividend non-negative so the division floors
				f_val = 3200 + (c_val * 9 + 40500) / 5 - 8100;
				h_val = (10000 * int'(raw_hum)) / 65535;
				rd.temp_c = 15'(c_val);
				rd.temp_f = 16'(f_val);
				rd.hum    = 14'(h_val);
				rd.ok     = 1'b1;
			end
			readings_due.push_back(rd);
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic sof);
		byte_backlog.push_back('{data: b, sof: sof});
		queued_bytes++;
	endtask

	// full frame; corrupt bit 0 spoils the temperature crc, bit 1 the humidity crc
	task automatic queue_frame(input logic sof, input logic [15:0] t, input logic [15:0] h,
		input logic [1:0] corrupt);
		logic [7:0] crc_t;
		logic [7:0] crc_h;
		crc_t = crc8_update(crc8_update(CRC_INIT, t[15:8]), t[7:0]);
		crc_h = crc8_update(crc8_update(CRC_INIT, h[15:8]), h[7:0]);
		if (corrupt[0]) crc_t ^= 8'($urandom_range(1, 255));
		if (corrupt[1]) crc_h ^= 8'($urandom_range(1, 255));
		queue_byte(t[15:8], sof);
		queue_byte(t[7:0], 1'b0);
		queue_byte(crc_t, 1'b0);
		queue_byte(h[15:8], 1'b0);
		queue_byte(h[7:0], 1'b0);
		queue_byte(crc_h, 1'b0);
	endtask

	// raw word with the scale ends favoured
	function automatic logic [15:0] pick_word();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// mostly well-formed frames, some spoilt crcs, the rest truncated frames and stray bytes
	task automatic queue_random(input int n_bytes);
		int         stop_at;
		int         cut;
		logic [1:0] corrupt;
		logic [7:0] crc_t;
		logic [15:0] t;
		stop_at = queued_bytes + n_bytes;
		while (queued_bytes < stop_at) begin
			if ($urandom_range(99) < 85) begin
				corrupt = ($urandom_range(99) < 15) ? 2'($urandom_range(1, 3)) : 2'b00;
				queue_frame(aligned ? 1'($urandom_range(1)) : 1'b1, pick_word(), pick_word(),
					corrupt);
				aligned = 1'b1;
			end else if ($urandom_range(1)) begin
				t     = pick_word();
				crc_t = crc8_update(crc8_update(CRC_INIT, t[15:8]), t[7:0]);
				cut   = $urandom_range(1, 5);
				queue_byte(t[15:8], 1'b1);
				if (cut > 1) queue_byte(t[7:0], 1'b0);
				if (cut > 2) queue_byte(crc_t, 1'b0);
				if (cut > 3) queue_byte(8'($urandom_range(255)), 1'b0);
				if (cut > 4) queue_byte(8'($urandom_range(255)), 1'b0);
				aligned = 1'b0;
			end else begin
				repeat ($urandom_range(1, 3))
					queue_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
				aligned = 1'b0;
			end
		end
	endtask

	// hold the sender back until every reading has come out
	task automatic drain();
		while (byte_backlog.size() != 0 || byte_valid || readings_due.size() != 0)
			@(negedge clk);
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_data  <= 8'h00;
			byte_sof   <= 1'b0;
		end else begin
			if (byte_valid && bytes_if.ready) begin
				decode_byte(byte_data, byte_sof);
				bytes_sent++;
			end
			if (!byte_valid || bytes_if.ready) begin
				if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					byte_valid <= 1'b1;
					byte_data  <= byte_backlog[0].data;
					byte_sof   <= byte_backlog[0].sof;
					void'(byte_backlog.pop_front());
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin : result_check
		reading_t want;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			if (result_if.valid && res_ready) begin
				if (readings_due.size() == 0) begin
					$error("reading transfer with no frame pending");
					error_count++;
				end else begin
					want = readings_due.pop_front();
					if (want.ok) frames_good++;
					else frames_rejected++;
					if (result_if.temp_centi_c !== want.temp_c) begin
						$error("temp_centi_c: expected %0d, got %0d", want.temp_c,
							result_if.temp_centi_c);
						error_count++;
					end
					if (result_if.temp_centi_f !== want.temp_f) begin
						$error("temp_centi_f: expected %0d, got %0d", want.temp_f,
							result_if.temp_centi_f);
						error_count++;
					end
					if (result_if.humidity_centi !== want.hum) begin
						$error("humidity_centi: expected %0d, got %0d", want.hum,
							result_if.humidity_centi);
						error_count++;
					end
					if (result_if.frame_valid !== want.ok) begin
						$error("frame_valid: expected %0d, got %0d", want.ok,
							result_if.frame_valid);
						error_count++;
					end
				end
			end
			res_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && bytes_if.ready) || (result_if.valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus sequence
	initial begin
		wait (arst_n);
		@(negedge clk);

		// scale ends, free running, resync over a partial frame, each crc spoilt
		queue_frame(1'b1, 16'h0000, 16'h0000, 2'b00);
		queue_frame(1'b0, 16'hFFFF, 16'hFFFF, 2'b00);
		queue_byte(8'hA5, 1'b1);
		queue_byte(8'h5A, 1'b0);
		queue_frame(1'b1, 16'h6666, 16'h8000, 2'b01);
		queue_frame(1'b0, 16'h1234, 16'h9ABC, 2'b10);
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			send_idle_pct  = SEND_IDLE_PCT[ph];
			recv_stall_pct = RECV_STALL_PCT[ph];
			queue_random(RANDOM_BYTES / N_PHASES);
			drain();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (readings_due.size() != 0) begin
			$error("%0d readings never came out", readings_due.size());
			error_count++;
		end

		$display("sent %0d bytes; checked %0d frames with good crc and %0d rejected",
			bytes_sent, frames_good, frames_rejected);
		$display("idling covered: none, sender only, receiver only, both; %0d errors",
			error_count);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
